### sv/rvx_pkg.sv
package rvx_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned MEM_BYTES = 4096;

  typedef enum logic [5:0] {
    OP_LUI = 6'd0, OP_AUIPC = 6'd1, OP_JAL = 6'd2, OP_JALR = 6'd3,
    OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BLT = 6'd6, OP_BLTU = 6'd7,
    OP_BGE = 6'd8, OP_BGEU = 6'd9, OP_ADDI = 6'd10, OP_SLTI = 6'd11,
    OP_SLTIU = 6'd12, OP_XORI = 6'd13, OP_ANDI = 6'd14, OP_ORI = 6'd15,
    OP_SLLI = 6'd16, OP_SRLI = 6'd17, OP_SRAI = 6'd18, OP_ADD = 6'd19,
    OP_SUB = 6'd20, OP_SLL = 6'd21, OP_SRL = 6'd22, OP_SRA = 6'd23,
    OP_SLT = 6'd24, OP_SLTU = 6'd25, OP_XOR = 6'd26, OP_AND = 6'd27,
    OP_OR = 6'd28, OP_ADDIW = 6'd29, OP_SLLIW = 6'd30, OP_SRLIW = 6'd31,
    OP_SRAIW = 6'd32, OP_ADDW = 6'd33, OP_SUBW = 6'd34, OP_SLLW = 6'd35,
    OP_SRLW = 6'd36, OP_SRAW = 6'd37, OP_LB = 6'd38, OP_LH = 6'd39,
    OP_LW = 6'd40, OP_LD = 6'd41, OP_SB = 6'd42, OP_SH = 6'd43,
    OP_SW = 6'd44, OP_SD = 6'd45, OP_LBU = 6'd46, OP_LHU = 6'd47,
    OP_LWU = 6'd48
  } op_t;

  typedef struct packed {
    logic [5:0]  operation;
    logic [4:0]  dest_index;
    logic [4:0]  src1_index;
    logic [4:0]  src2_index;
    logic [19:0] immediate;
  } instr_t;

  typedef struct packed {
    logic [63:0] next_pc;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [63:0] write_value;
    logic        branch_taken;
  } result_t;

  // Load request handed from the execute stage to the memory stage.
  typedef struct packed {
    logic       is_load;
    logic [1:0] size_log2;
    logic       sign_ext;
  } load_ctl_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

### sv/rvx_stream_if.sv
interface rvx_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/rv64i_instruction_execute_top.sv
// Executes one decoded RV64I instruction per transfer and returns the next PC and
// register write. An item is latched into an input register, executed against the
// register file and PC once no load is in flight and the output slot is free, and
// its result placed in an output register; a load first reads the synchronous
// data memory, and its result is formed from the read data. A new item is accepted
// every cycle when no load is in flight and the output is not stalled; an item
// behind a load waits for the load's write-back. Asserting cfg_we sets the PC to
// cfg_wdata. The data memory holds MEM_BYTES bytes as fixed in the package.
module rv64i_instruction_execute_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_wdata,
  rvx_stream_if.sink          in_ch,
  rvx_stream_if.source        out_ch
);
  import rvx_pkg::*;

  logic        iv, ld_busy, ov, adv, exec;
  instr_t      ir;
  logic [63:0] pc, a, b, value, npc, addr, rdata, ldv;
  logic        writes, taken, is_store;
  logic [1:0]  ssize;
  load_ctl_t   ld, ldr;
  result_t     res, lres;
  logic        w_en;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [63:0] rf_wd;

  rvx_regfile u_rf (
    .clk(clk), .rst(rst), .rs1(ir.src1_index), .rs2(ir.src2_index),
    .rdata1(a), .rdata2(b), .we(rf_we), .wa(rf_wa), .wd(rf_wd)
  );

  rvx_alu u_alu (
    .instr(ir), .a(a), .b(b), .pc(pc), .value(value), .writes(writes),
    .next_pc(npc), .taken(taken), .addr(addr), .is_store(is_store),
    .size_log2(ssize), .ld(ld)
  );

  // Output slot is free when empty or being drained.
  assign adv = !ov || out_ch.ready;
  assign exec = iv && !ld_busy && adv;
  assign in_ch.ready = !iv || exec;
  assign w_en = exec && writes && !ld.is_load;

  // Load data is written back in the cycle after the memory read.
  assign rf_we = w_en || (ld_busy && lres.write_enable);
  assign rf_wa = ld_busy ? lres.write_index : ir.dest_index;
  assign rf_wd = ld_busy ? ldv : value;

  rvx_dmem u_mem (
    .clk(clk), .wr_en(exec && is_store), .rd_en(exec && ld.is_load),
    .addr(addr), .size_log2(exec && is_store ? ssize : ld.size_log2),
    .wdata(b), .rdata(rdata)
  );

  always_comb begin
    case (ldr.size_log2)
      2'd0: ldv = ldr.sign_ext ? {{56{rdata[7]}}, rdata[7:0]} : {56'd0, rdata[7:0]};
      2'd1: ldv = ldr.sign_ext ? {{48{rdata[15]}}, rdata[15:0]} : {48'd0, rdata[15:0]};
      2'd2: ldv = ldr.sign_ext ? sext32(rdata[31:0]) : {32'd0, rdata[31:0]};
      default: ldv = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
      ov <= 1'b0;
      ld_busy <= 1'b0;
      pc <= 64'd0;
    end else begin
      if (cfg_we) begin
        pc <= cfg_wdata;
      end else if (exec) begin
        pc <= npc;
      end
      if (in_ch.valid && in_ch.ready) begin
        iv <= 1'b1;
        ir <= in_ch.payload;
      end else if (exec) begin
        iv <= 1'b0;
      end
      if (ld_busy || (exec && !ld.is_load)) begin
        ov <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        ov <= 1'b0;
      end
      ld_busy <= exec && ld.is_load;
      if (ld_busy) begin
        res <= '{next_pc: lres.next_pc, write_enable: lres.write_enable,
                 write_index: lres.write_index,
                 write_value: lres.write_enable ? ldv : 64'd0, branch_taken: 1'b0};
      end else if (exec && !ld.is_load) begin
        res <= '{next_pc: npc, write_enable: writes && ir.dest_index != 5'd0,
                 write_index: (writes && ir.dest_index != 5'd0) ? ir.dest_index : 5'd0,
                 write_value: (writes && ir.dest_index != 5'd0) ? value : 64'd0,
                 branch_taken: taken};
      end
      if (exec && ld.is_load) begin
        ldr <= ld;
        lres <= '{next_pc: npc, write_enable: ir.dest_index != 5'd0,
                  write_index: ir.dest_index, write_value: 64'd0, branch_taken: 1'b0};
      end
    end
  end

  assign out_ch.valid = ov;
  assign out_ch.payload = res;

  a_ld_one_cycle: assert property (@(posedge clk) disable iff (rst)
    ld_busy |=> !ld_busy) else $error("load occupied two cycles");
  a_exec_slot: assert property (@(posedge clk) disable iff (rst)
    exec |-> adv) else $error("executed into a full output slot");
  a_ld_out: assert property (@(posedge clk) disable iff (rst)
    ld_busy |=> ov) else $error("load result not presented");

endmodule

### sv/rvx_alu.sv
module rvx_alu (
  input  rvx_pkg::instr_t     instr,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  input  logic [63:0]         pc,
  output logic [63:0]         value,
  output logic                writes,
  output logic [63:0]         next_pc,
  output logic                taken,
  output logic [63:0]         addr,
  output logic                is_store,
  output logic [1:0]          size_log2,
  output rvx_pkg::load_ctl_t  ld
);
  import rvx_pkg::*;

  logic [63:0] i12, sa, sb, ui, seq, sum_i, sum_b, dif_b;
  logic [31:0] lo, sraw_i, sraw_r;
  logic        cond, is_br;
  op_t         op;

  assign op    = op_t'(instr.operation);
  assign i12   = {{52{instr.immediate[11]}}, instr.immediate[11:0]};
  assign ui    = sext32({instr.immediate, 12'd0});
  assign sa    = a ^ {1'b1, 63'd0};
  assign sb    = b ^ {1'b1, 63'd0};
  assign seq   = pc + 64'd4;
  assign sum_i = a + i12;
  assign sum_b = a + b;
  assign dif_b = a - b;
  assign lo    = a[31:0];
  assign sraw_i = $signed(lo) >>> instr.immediate[4:0];
  assign sraw_r = $signed(lo) >>> b[4:0];
  assign addr  = sum_i;

  always_comb begin
    value = '0;
    writes = 1'b1;
    cond = 1'b0;
    is_br = 1'b0;
    next_pc = seq;
    taken = 1'b0;
    is_store = 1'b0;
    size_log2 = 2'd0;
    ld = '0;
    case (op)
      OP_LUI: value = ui;
      OP_AUIPC: value = pc + ui;
      OP_JAL: begin
        value = seq;
        next_pc = pc + {{44{instr.immediate[19]}}, instr.immediate};
        taken = 1'b1;
      end
      OP_JALR: begin
        value = seq;
        next_pc = {sum_i[63:1], 1'b0};
        taken = 1'b1;
      end
      OP_BEQ: begin writes = 1'b0; is_br = 1'b1; cond = (a == b); end
      OP_BNE: begin writes = 1'b0; is_br = 1'b1; cond = (a != b); end
      OP_BLT: begin writes = 1'b0; is_br = 1'b1; cond = (sa < sb); end
      OP_BLTU: begin writes = 1'b0; is_br = 1'b1; cond = (a < b); end
      OP_BGE: begin writes = 1'b0; is_br = 1'b1; cond = (sa >= sb); end
      OP_BGEU: begin writes = 1'b0; is_br = 1'b1; cond = (a >= b); end
      OP_ADDI: value = sum_i;
      OP_SLTI: value = {63'd0, sa < (i12 ^ {1'b1, 63'd0})};
      OP_SLTIU: value = {63'd0, a < i12};
      OP_XORI: value = a ^ i12;
      OP_ANDI: value = a & i12;
      OP_ORI: value = a | i12;
      OP_SLLI: value = a << instr.immediate[5:0];
      OP_SRLI: value = a >> instr.immediate[5:0];
      OP_SRAI: value = $signed(a) >>> instr.immediate[5:0];
      OP_ADD: value = sum_b;
      OP_SUB: value = dif_b;
      OP_SLL: value = a << b[5:0];
      OP_SRL: value = a >> b[5:0];
      OP_SRA: value = $signed(a) >>> b[5:0];
      OP_SLT: value = {63'd0, sa < sb};
      OP_SLTU: value = {63'd0, a < b};
      OP_XOR: value = a ^ b;
      OP_AND: value = a & b;
      OP_OR: value = a | b;
      OP_ADDIW: value = sext32(sum_i[31:0]);
      OP_SLLIW: value = sext32(lo << instr.immediate[4:0]);
      OP_SRLIW: value = sext32(lo >> instr.immediate[4:0]);
      OP_SRAIW: value = sext32(sraw_i);
      OP_ADDW: value = sext32(sum_b[31:0]);
      OP_SUBW: value = sext32(dif_b[31:0]);
      OP_SLLW: value = sext32(lo << b[4:0]);
      OP_SRLW: value = sext32(lo >> b[4:0]);
      OP_SRAW: value = sext32(sraw_r);
      OP_LB: ld = '{is_load: 1'b1, size_log2: 2'd0, sign_ext: 1'b1};
      OP_LH: ld = '{is_load: 1'b1, size_log2: 2'd1, sign_ext: 1'b1};
      OP_LW: ld = '{is_load: 1'b1, size_log2: 2'd2, sign_ext: 1'b1};
      OP_LD: ld = '{is_load: 1'b1, size_log2: 2'd3, sign_ext: 1'b0};
      OP_LBU: ld = '{is_load: 1'b1, size_log2: 2'd0, sign_ext: 1'b0};
      OP_LHU: ld = '{is_load: 1'b1, size_log2: 2'd1, sign_ext: 1'b0};
      OP_LWU: ld = '{is_load: 1'b1, size_log2: 2'd2, sign_ext: 1'b0};
      OP_SB: begin writes = 1'b0; is_store = 1'b1; size_log2 = 2'd0; end
      OP_SH: begin writes = 1'b0; is_store = 1'b1; size_log2 = 2'd1; end
      OP_SW: begin writes = 1'b0; is_store = 1'b1; size_log2 = 2'd2; end
      OP_SD: begin writes = 1'b0; is_store = 1'b1; size_log2 = 2'd3; end
      default: writes = 1'b0;
    endcase
    if (is_br && cond) begin
      next_pc = pc + i12;
      taken = 1'b1;
    end
  end

endmodule

### sv/rvx_dmem.sv
module rvx_dmem (
  input  logic        clk,
  input  logic        wr_en,
  input  logic        rd_en,
  input  logic [63:0] addr,
  input  logic [1:0]  size_log2,
  input  logic [63:0] wdata,
  output logic [63:0] rdata
);
  import rvx_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);

  // Eight byte banks; bank k holds the bytes whose address is k modulo eight, so an
  // access of up to eight bytes touches each bank at most once.
  logic [AW-1:0] base;
  logic [3:0]    nbytes;
  logic [2:0]    rd_off;
  logic [7:0]    bank_q [8];

  assign base = addr[AW-1:0];
  assign nbytes = 4'd1 << size_log2;

  generate
    for (genvar k = 0; k < 8; k++) begin : g_bank
      logic [7:0]    bank [MEM_BYTES/8];
      logic [7:0]    q;
      logic [2:0]    lane;
      logic [AW-1:0] byte_addr;

      // The byte of the access that falls into this bank, and its wrapped address.
      assign lane = 3'(k) - base[2:0];
      assign byte_addr = base + AW'(lane);

      always_ff @(posedge clk) begin
        if (wr_en && ({1'b0, lane} < nbytes)) begin
          bank[byte_addr[AW-1:3]] <= wdata[8*lane +: 8];
        end
        if (rd_en) begin
          q <= bank[byte_addr[AW-1:3]];
        end
      end

      assign bank_q[k] = q;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_off <= base[2:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rdata[8*i +: 8] = bank_q[3'(rd_off + 3'(i))];
    end
  end

endmodule

### sv/rvx_regfile.sv
module rvx_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  rs1,
  input  logic [4:0]  rs2,
  output logic [63:0] rdata1,
  output logic [63:0] rdata2,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [63:0] wd
);
  import rvx_pkg::*;

  logic [63:0] regs [32];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        regs[i] <= '0;
      end
    end else if (we && wa != 5'd0) begin
      regs[wa] <= wd;
    end
  end

  assign rdata1 = (rs1 == 5'd0) ? 64'd0 : regs[rs1];
  assign rdata2 = (rs2 == 5'd0) ? 64'd0 : regs[rs2];

endmodule
